@@ rtl/core/fid_pkg.sv @@
// Shared types and constants of the fault injection decider.
// Depends on nothing; every other file refers to it by scoped names.
package fid_pkg;

    // Field widths of the channels and the configuration port
    localparam int ACTION_W   = 2;
    localparam int VALUE_W    = 64;
    localparam int SLOT_W     = 12;
    localparam int HIT_W      = 32;
    localparam int MODE_W     = 2;
    localparam int LIMIT_W    = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // Input actions
    localparam logic [ACTION_W-1:0] ACT_CALL     = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_ADD_DIS  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_ADD_EN   = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_ADD_FAIL = 2'd3;

    // Operating modes; any other code injects faults
    localparam logic [MODE_W-1:0] MODE_OFF   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TRACE = 2'd1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRACE_LIMIT = 2'd1;

    // Reset value of the trace limit
    localparam logic [LIMIT_W-1:0] TRACE_LIMIT_RST = 13'd4096;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic start;    // accept a beat, latch it and do the single-cycle work
        logic scan;     // advance the list walk by one entry
        logic resolve;  // walk finished, settle the inject decision
        logic emit;     // move the result into the output register
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic need_scan;  // the offered beat is a call that checks the lists
        logic scan_done;  // every entry has been compared
    } t_stat;

endpackage

@@ rtl/core/fid_in_if.sv @@
// Input channel of the fault injection decider: one action and one value per beat.
// Depends on fid_pkg for the field widths.
interface fid_in_if;
    logic                         valid;
    logic                         ready;
    logic [fid_pkg::ACTION_W-1:0] action;
    logic [fid_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

@@ rtl/core/fid_out_if.sv @@
// Result channel of the fault injection decider: one decision per beat.
// Depends on fid_pkg for the field widths.
interface fid_out_if;
    logic                        valid;
    logic                        ready;
    logic                        inject;
    logic                        logged;
    logic [fid_pkg::SLOT_W-1:0]  log_slot;
    logic [fid_pkg::VALUE_W-1:0] log_value;
    logic [fid_pkg::HIT_W-1:0]   hit_number;
    logic                        list_full;

    modport source (output valid, output inject, output logged, output log_slot,
                    output log_value, output hit_number, output list_full, input ready);
    modport sink   (input valid, input inject, input logged, input log_slot,
                    input log_value, input hit_number, input list_full, output ready);
endinterface

@@ rtl/core/fid_ctrl.sv @@
// Controller of the fault injection decider: sequences accept, list walk and output.
// Depends on fid_pkg for the command and status structs.
module fid_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  fid_pkg::t_stat i_st,
    output fid_pkg::t_cmd  o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    t_state r_state;
    logic   r_in_ready;
    logic   r_out_valid;

    // Decode commands from the current state
    always_comb begin
        o_cmd.start   = i_in_valid && r_in_ready;
        o_cmd.scan    = (r_state == ST_SCAN) && !i_st.scan_done;
        o_cmd.resolve = (r_state == ST_SCAN) && i_st.scan_done;
        o_cmd.emit    = (r_state == ST_FINISH) && (!r_out_valid || i_out_ready);
    end

    // Hold state, input ready and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (o_cmd.start) begin
                        r_in_ready <= 1'b0;
                        r_state    <= i_st.need_scan ? ST_SCAN : ST_FINISH;
                    end
                end
                ST_SCAN: begin
                    if (i_st.scan_done) begin
                        r_state <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (o_cmd.emit) begin
                        r_in_ready <= 1'b1;
                        r_state    <= ST_IDLE;
                    end
                end
                default: begin
                    r_in_ready <= 1'b1;
                    r_state    <= ST_IDLE;
                end
            endcase

            // Output register: fill on emit, drop when taken
            if (o_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_ready  = r_in_ready;
    assign o_out_valid = r_out_valid;

endmodule

@@ rtl/core/fid_dp.sv @@
// Datapath of the fault injection decider: configuration, counters, list memories,
// the parallel list walk and the result and output registers. Depends on fid_pkg.
module fid_dp #(
    parameter int LIST_DEPTH  = 64,
    parameter int TRACE_DEPTH = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write port
    input  logic                           i_cfg_we,
    input  logic [fid_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [fid_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input payload
    input  logic [fid_pkg::ACTION_W-1:0]   i_action,
    input  logic [fid_pkg::VALUE_W-1:0]    i_value,
    // control
    input  fid_pkg::t_cmd                  i_cmd,
    output fid_pkg::t_stat                 o_st,
    // output payload
    output logic                           o_inject,
    output logic                           o_logged,
    output logic [fid_pkg::SLOT_W-1:0]     o_log_slot,
    output logic [fid_pkg::VALUE_W-1:0]    o_log_value,
    output logic [fid_pkg::HIT_W-1:0]      o_hit_number,
    output logic                           o_list_full
);

    localparam int CW   = $clog2(LIST_DEPTH + 1);
    localparam int IW   = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int LW   = $clog2(TRACE_DEPTH + 1);
    localparam int CMPW = (LW > fid_pkg::LIMIT_W) ? LW : fid_pkg::LIMIT_W;

    localparam logic [CW-1:0]   LIST_FULL_CNT = CW'(LIST_DEPTH);
    localparam logic [CMPW-1:0] TRACE_CAP     = CMPW'(TRACE_DEPTH);

    // configuration
    logic [fid_pkg::MODE_W-1:0]  r_mode;
    logic [fid_pkg::LIMIT_W-1:0] r_trace_limit;

    // persistent state
    logic [fid_pkg::HIT_W-1:0] r_hit_count;
    logic                      r_fault_seen;
    logic [LW-1:0]             r_log_count;
    logic [CW-1:0]             r_dis_cnt;
    logic [CW-1:0]             r_en_cnt;
    logic [CW-1:0]             r_fail_cnt;

    // list memories and their registered read data
    logic [fid_pkg::VALUE_W-1:0] r_dis_mem  [LIST_DEPTH];
    logic [fid_pkg::VALUE_W-1:0] r_en_mem   [LIST_DEPTH];
    logic [fid_pkg::HIT_W-1:0]   r_fail_mem [LIST_DEPTH];
    logic [fid_pkg::VALUE_W-1:0] r_dis_rd;
    logic [fid_pkg::VALUE_W-1:0] r_en_rd;
    logic [fid_pkg::HIT_W-1:0]   r_fail_rd;

    // walk state
    logic [fid_pkg::VALUE_W-1:0] r_key;
    logic [CW-1:0]               r_idx;
    logic                        r_dis_vld;
    logic                        r_en_vld;
    logic                        r_fail_vld;
    logic                        r_dis_hit;
    logic                        r_en_hit;
    logic                        r_fail_hit;

    // result of the current item, and the output register
    logic                        r_res_inject;
    logic                        r_res_logged;
    logic [fid_pkg::SLOT_W-1:0]  r_res_slot;
    logic [fid_pkg::VALUE_W-1:0] r_res_value;
    logic                        r_res_full;
    logic                        r_out_inject;
    logic                        r_out_logged;
    logic [fid_pkg::SLOT_W-1:0]  r_out_slot;
    logic [fid_pkg::VALUE_W-1:0] r_out_value;
    logic [fid_pkg::HIT_W-1:0]   r_out_hit;
    logic                        r_out_full;

    // decode of the offered beat
    logic                        is_call;
    logic                        call_on;
    logic                        do_log;
    logic                        log_full;
    logic [CMPW-1:0]             eff_limit;
    logic                        dis_full;
    logic                        en_full;
    logic                        fail_full;
    logic                        add_dropped;
    logic [CW-1:0]               max_cnt;
    logic                        issue;
    logic                        inj;
    logic [fid_pkg::HIT_W-1:0]   n_hit_count;

    always_comb begin
        is_call   = (i_action == fid_pkg::ACT_CALL);
        call_on   = is_call && (r_mode != fid_pkg::MODE_OFF);
        eff_limit = (CMPW'(r_trace_limit) < TRACE_CAP) ? CMPW'(r_trace_limit) : TRACE_CAP;
        log_full  = (CMPW'(r_log_count) >= eff_limit);
        do_log    = call_on && ((r_mode == fid_pkg::MODE_TRACE) || r_fault_seen) && !log_full;
        n_hit_count = r_hit_count + 1'b1;

        dis_full  = (r_dis_cnt == LIST_FULL_CNT);
        en_full   = (r_en_cnt == LIST_FULL_CNT);
        fail_full = (r_fail_cnt == LIST_FULL_CNT);
        case (i_action)
            fid_pkg::ACT_ADD_DIS:  add_dropped = dis_full;
            fid_pkg::ACT_ADD_EN:   add_dropped = en_full;
            fid_pkg::ACT_ADD_FAIL: add_dropped = fail_full;
            default:               add_dropped = 1'b0;
        endcase

        // walk length is the longest of the three lists
        max_cnt = r_dis_cnt;
        if (r_en_cnt > max_cnt) max_cnt = r_en_cnt;
        if (r_fail_cnt > max_cnt) max_cnt = r_fail_cnt;
        issue = (r_idx < max_cnt);

        inj = !r_dis_hit && (r_en_hit || r_fail_hit);

        o_st.need_scan = call_on && (r_mode != fid_pkg::MODE_TRACE);
        o_st.scan_done = !issue && !r_dis_vld && !r_en_vld && !r_fail_vld;
    end

    // Configuration writes; unknown indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= fid_pkg::MODE_OFF;
            r_trace_limit <= fid_pkg::TRACE_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                fid_pkg::CFG_MODE:        r_mode        <= i_cfg_data[fid_pkg::MODE_W-1:0];
                fid_pkg::CFG_TRACE_LIMIT: r_trace_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Counters, sticky fault flag and walk control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_count  <= '0;
            r_fault_seen <= 1'b0;
            r_log_count  <= '0;
            r_dis_cnt    <= '0;
            r_en_cnt     <= '0;
            r_fail_cnt   <= '0;
            r_idx        <= '0;
            r_dis_vld    <= 1'b0;
            r_en_vld     <= 1'b0;
            r_fail_vld   <= 1'b0;
            r_dis_hit    <= 1'b0;
            r_en_hit     <= 1'b0;
            r_fail_hit   <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_idx      <= '0;
                r_dis_vld  <= 1'b0;
                r_en_vld   <= 1'b0;
                r_fail_vld <= 1'b0;
                r_dis_hit  <= 1'b0;
                r_en_hit   <= 1'b0;
                r_fail_hit <= 1'b0;
                if (call_on) r_hit_count <= n_hit_count;
                if (do_log) r_log_count <= r_log_count + 1'b1;
                if (i_action == fid_pkg::ACT_ADD_DIS && !dis_full) r_dis_cnt <= r_dis_cnt + 1'b1;
                if (i_action == fid_pkg::ACT_ADD_EN && !en_full) r_en_cnt <= r_en_cnt + 1'b1;
                if (i_action == fid_pkg::ACT_ADD_FAIL && !fail_full) begin
                    r_fail_cnt <= r_fail_cnt + 1'b1;
                end
            end
            // Advance the walk: issue one read per list, compare last cycle's data
            if (i_cmd.scan) begin
                if (issue) r_idx <= r_idx + 1'b1;
                r_dis_vld  <= issue && (r_idx < r_dis_cnt);
                r_en_vld   <= issue && (r_idx < r_en_cnt);
                r_fail_vld <= issue && (r_idx < r_fail_cnt);
                r_dis_hit  <= r_dis_hit || (r_dis_vld && (r_dis_rd == r_key));
                r_en_hit   <= r_en_hit || (r_en_vld && (r_en_rd == r_key));
                r_fail_hit <= r_fail_hit || (r_fail_vld && (r_fail_rd == r_hit_count));
            end
            if (i_cmd.resolve && inj) r_fault_seen <= 1'b1;
        end
    end

    // List memories: append on add, read at the walk index
    always_ff @(posedge i_clk) begin
        if (i_cmd.start && i_action == fid_pkg::ACT_ADD_DIS && !dis_full) begin
            r_dis_mem[r_dis_cnt[IW-1:0]] <= i_value;
        end
        r_dis_rd <= r_dis_mem[r_idx[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start && i_action == fid_pkg::ACT_ADD_EN && !en_full) begin
            r_en_mem[r_en_cnt[IW-1:0]] <= i_value;
        end
        r_en_rd <= r_en_mem[r_idx[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start && i_action == fid_pkg::ACT_ADD_FAIL && !fail_full) begin
            r_fail_mem[r_fail_cnt[IW-1:0]] <= i_value[fid_pkg::HIT_W-1:0];
        end
        r_fail_rd <= r_fail_mem[r_idx[IW-1:0]];
    end

    // Result and output registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_key        <= i_value;
            r_res_inject <= 1'b0;
            r_res_logged <= do_log;
            r_res_slot   <= do_log ? fid_pkg::SLOT_W'(r_log_count) : '0;
            r_res_value  <= do_log ? i_value : '0;
            r_res_full   <= add_dropped;
        end
        if (i_cmd.resolve) begin
            r_res_inject <= inj;
        end
        if (i_cmd.emit) begin
            r_out_inject <= r_res_inject;
            r_out_logged <= r_res_logged;
            r_out_slot   <= r_res_slot;
            r_out_value  <= r_res_value;
            r_out_hit    <= r_hit_count;
            r_out_full   <= r_res_full;
        end
    end

    assign o_inject     = r_out_inject;
    assign o_logged     = r_out_logged;
    assign o_log_slot   = r_out_slot;
    assign o_log_value  = r_out_value;
    assign o_hit_number = r_out_hit;
    assign o_list_full  = r_out_full;

endmodule

@@ rtl/core/fault_injection_decider_top.sv @@
// Fault injection decider: one result beat for every input beat, in order. A load beat
// or a call in off or trace mode goes from accept into the result register and then the
// output register; a call in inject mode walks the disabled, enabled and fail lists side
// by side, one entry of each per cycle through each list memory's single read port, up to
// the longest list's fill, before its result moves to the output register. One item is in work at a time,
// and a finished result waits in the output register while the next beat is accepted.
// The lists need no clearing after reset; only their fill counts are cleared.
// Depends on fid_pkg, fid_in_if, fid_out_if, fid_ctrl and fid_dp.
module fault_injection_decider_top #(
    parameter int LIST_DEPTH  = 64,
    parameter int TRACE_DEPTH = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [fid_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [fid_pkg::CFG_DATA_W-1:0] i_cfg_data,
    fid_in_if.sink                         i_in,
    fid_out_if.source                      o_out
);

    fid_pkg::t_cmd  cmd;
    fid_pkg::t_stat st;

    fid_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_st        (st),
        .o_cmd       (cmd)
    );

    fid_dp #(
        .LIST_DEPTH  (LIST_DEPTH),
        .TRACE_DEPTH (TRACE_DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_action     (i_in.action),
        .i_value      (i_in.value),
        .i_cmd        (cmd),
        .o_st         (st),
        .o_inject     (o_out.inject),
        .o_logged     (o_out.logged),
        .o_log_slot   (o_out.log_slot),
        .o_log_value  (o_out.log_value),
        .o_hit_number (o_out.hit_number),
        .o_list_full  (o_out.list_full)
    );

`ifndef SYNTHESIS
    // One item at a time: an accepted beat closes the input until its result is out
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input accepted while an item is in work");

    // Never overwrite a result that still waits in the output register
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> (!o_out.valid || o_out.ready))
        else $error("result emitted over a pending output beat");

    // A fault comes only from a call, never from a dropped add
    a_inject_call: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.inject) |-> !o_out.list_full)
        else $error("inject and list full on the same beat");
`endif

endmodule
